### src/tkeg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// tkeg_pkg
// Types and constants shared by the touch-to-key event generator.
// ---------------------------------------------------------------------------
package tkeg_pkg;

    // Coordinate and key matrix geometry
    localparam int XW         = 10;          // touch coordinate width
    localparam int RW         = 2;           // key_row width
    localparam int CW         = 4;           // key_col width
    localparam int ROWS       = 4;
    localparam int COLS       = 14;
    localparam int KEY_HEIGHT = 22;
    localparam int RULE_ROWS  = 2;

    // Modifier cells
    localparam logic [RW-1:0] FN_ROW    = RW'(2);
    localparam logic [CW-1:0] FN_COL    = CW'(0);
    localparam logic [RW-1:0] SHIFT_ROW = RW'(2);
    localparam logic [CW-1:0] SHIFT_COL = CW'(1);

    // Configuration register indexes (word address)
    localparam int AW = 4;
    localparam logic [1:0] REG_ENABLED     = 2'd0;
    localparam logic [1:0] REG_PANEL_WIDTH = 2'd1;
    localparam logic [1:0] REG_BAND_Y      = 2'd2;

    typedef struct packed {
        logic          touch_active;
        logic [XW-1:0] touch_x;
        logic [XW-1:0] touch_y;
    } t_touch;

    typedef struct packed {
        logic          is_press;
        logic [RW-1:0] key_row;
        logic [CW-1:0] key_col;
        logic          last;
    } t_key_event;

endpackage

`default_nettype wire

### src/touch_to_key_event_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// touch_to_key_event_generator
// Turns polled touch samples into key press/release beats for a key matrix,
// using one shared compare-subtract divider for the row and column mapping.
// ---------------------------------------------------------------------------
// A press is accepted in S_IDLE, then runs two row steps in S_ROW and four column steps in S_COL
//   on the shared restoring divider (one quotient bit per cycle).
// A release of a key other than fn or shift emits 2 or 4 output beats, one per cycle while unstalled.
// A sample that changes nothing is consumed in S_IDLE; one sample is in work at a time.
// Reset (i_rst_n low, synchronous): enabled=1, panel_width=320, band row=150,
//   no cell held, latches clear, output empty.
module touch_to_key_event_generator
    import tkeg_pkg::*;
(
    input  wire             i_clk,
    input  wire             i_rst_n,
    // sample channel
    input  wire             i_in_valid,
    output logic            o_in_stall,
    input  wire t_touch     i_in_data,
    // key event channel
    output logic            o_out_valid,
    input  wire             i_out_stall,
    output t_key_event      o_out_data,
    // configuration port
    input  wire             psel,
    input  wire             penable,
    input  wire             pwrite,
    input  wire  [AW-1:0]   paddr,
    input  wire  [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    localparam int DW   = XW + CW;                    // divider datapath width
    localparam int CNTW = (CW > 1) ? $clog2(CW) : 1;
    localparam logic [DW-1:0] ROW_LIMIT = DW'(KEY_HEIGHT * ROWS);
    localparam logic [DW-1:0] ROW_DVS   = DW'(KEY_HEIGHT << (RW - 1));

    // event slot codes within a run
    localparam logic [1:0] EV_MOD_DN = 2'd0;
    localparam logic [1:0] EV_KEY_DN = 2'd1;
    localparam logic [1:0] EV_KEY_UP = 2'd2;
    localparam logic [1:0] EV_MOD_UP = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ROW  = 4'b0010,
        S_COL  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state          r_state;
    logic            r_enabled;
    logic [XW-1:0]   r_panel_width;
    logic [XW-1:0]   r_band_y;
    logic            r_was_touching;
    logic            r_held_valid;
    logic [RW-1:0]   r_held_row;
    logic [CW-1:0]   r_held_col;
    logic            r_fn_latched;
    logic            r_shift_latched;
    logic            r_mod;
    logic [CW-1:0]   r_mod_col;
    logic [1:0]      r_ev;
    logic [XW-1:0]   r_x;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_dvs;
    logic [CW-1:0]   r_q;
    logic [CNTW-1:0] r_cnt;
    logic            r_out_valid;
    t_key_event      r_out_data;

    // ---------------- configuration ----------------
    logic       cfg_wr;
    logic [1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_idx)
            REG_ENABLED:     prdata = {31'd0, r_enabled};
            REG_PANEL_WIDTH: prdata = {{(32-XW){1'b0}}, r_panel_width};
            REG_BAND_Y:      prdata = {{(32-XW){1'b0}}, r_band_y};
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled     <= 1'b1;
            r_panel_width <= XW'(320);
            r_band_y      <= XW'(150);
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ENABLED:     r_enabled     <= pwdata[0];
                REG_PANEL_WIDTH: r_panel_width <= pwdata[XW-1:0];
                REG_BAND_Y:      r_band_y      <= pwdata[XW-1:0];
                default:         ;
            endcase
        end
    end

    // ---------------- sample decode ----------------
    logic          in_acc;
    logic          in_edge;
    logic [XW-1:0] dy;
    logic [XW-1:0] dr;
    logic          press_ok;
    logic          rel_fn;
    logic          rel_shift;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign in_edge    = r_enabled && (i_in_data.touch_active != r_was_touching);

    assign dy = i_in_data.touch_y - r_band_y;
    // the two-pixel rule at the top of the band truncates to row 0
    assign dr = (dy < XW'(RULE_ROWS)) ? '0 : dy - XW'(RULE_ROWS);
    // x < panel_width keeps the column below COLS and excludes a zero width
    assign press_ok = (i_in_data.touch_y >= r_band_y)
                   && (DW'(dr) < ROW_LIMIT)
                   && (i_in_data.touch_x < r_panel_width);

    assign rel_fn    = (r_held_row == FN_ROW) && (r_held_col == FN_COL);
    assign rel_shift = (r_held_row == SHIFT_ROW) && (r_held_col == SHIFT_COL);

    // ---------------- shared divider step ----------------
    logic          div_ge;
    logic [DW-1:0] n_rem;
    logic [CW-1:0] n_q;

    assign div_ge = (r_rem >= r_dvs);
    assign n_rem  = div_ge ? (r_rem - r_dvs) : r_rem;
    assign n_q    = {r_q[CW-2:0], div_ge};

    // ---------------- event run ----------------
    logic       out_free;
    logic [1:0] ev_slot;
    t_key_event ev;

    assign out_free = !r_out_valid || !i_out_stall;
    // without a latched modifier the run starts at the key press slot
    assign ev_slot  = r_mod ? r_ev : (r_ev + 2'd1);

    always_comb begin
        ev.key_row = r_held_row;
        ev.key_col = r_held_col;
        ev.last    = (ev_slot == EV_MOD_UP) || (!r_mod && (ev_slot == EV_KEY_UP));
        case (ev_slot)
            EV_MOD_DN: begin
                ev.is_press = 1'b1;
                ev.key_row  = FN_ROW;
                ev.key_col  = r_mod_col;
            end
            EV_KEY_DN: ev.is_press = 1'b1;
            EV_KEY_UP: ev.is_press = 1'b0;
            default: begin
                ev.is_press = 1'b0;
                ev.key_row  = FN_ROW;
                ev.key_col  = r_mod_col;
            end
        endcase
    end

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_was_touching  <= 1'b0;
            r_held_valid    <= 1'b0;
            r_held_row      <= '0;
            r_held_col      <= '0;
            r_fn_latched    <= 1'b0;
            r_shift_latched <= 1'b0;
            r_mod           <= 1'b0;
            r_ev            <= '0;
            r_cnt           <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid <= (r_state == S_EMIT);
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && in_edge) begin
                        r_was_touching <= i_in_data.touch_active;
                        if (i_in_data.touch_active) begin
                            if (press_ok) begin
                                r_x     <= i_in_data.touch_x;
                                r_rem   <= DW'(dr);
                                r_dvs   <= ROW_DVS;
                                r_q     <= '0;
                                r_cnt   <= CNTW'(RW - 1);
                                r_state <= S_ROW;
                            end
                        end else if (r_held_valid) begin
                            r_held_valid <= 1'b0;
                            if (rel_fn) begin
                                r_fn_latched    <= !r_fn_latched;
                                r_shift_latched <= 1'b0;
                            end else if (rel_shift) begin
                                r_shift_latched <= !r_shift_latched;
                                r_fn_latched    <= 1'b0;
                            end else begin
                                r_mod           <= r_fn_latched || r_shift_latched;
                                r_mod_col       <= r_fn_latched ? FN_COL : SHIFT_COL;
                                r_fn_latched    <= 1'b0;
                                r_shift_latched <= 1'b0;
                                r_ev            <= '0;
                                r_state         <= S_EMIT;
                            end
                        end
                    end
                end
                S_ROW: begin
                    if (r_cnt == '0) begin
                        r_held_row <= n_q[RW-1:0];
                        r_rem      <= DW'(r_x) * DW'(COLS);
                        r_dvs      <= DW'(r_panel_width) << (CW - 1);
                        r_q        <= '0;
                        r_cnt      <= CNTW'(CW - 1);
                        r_state    <= S_COL;
                    end else begin
                        r_rem <= n_rem;
                        r_dvs <= r_dvs >> 1;
                        r_q   <= n_q;
                        r_cnt <= r_cnt - CNTW'(1);
                    end
                end
                S_COL: begin
                    if (r_cnt == '0) begin
                        r_held_col   <= n_q;
                        r_held_valid <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_rem <= n_rem;
                        r_dvs <= r_dvs >> 1;
                        r_q   <= n_q;
                        r_cnt <= r_cnt - CNTW'(1);
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_data <= ev;
                        r_ev       <= r_ev + 2'd1;
                        if (ev.last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // ---------------- assertions ----------------
    a_latch_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_fn_latched && r_shift_latched))
        else $error("fn and shift latched together");

    a_no_hold_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> !r_held_valid)
        else $error("cell still held during event run");

    a_col_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COL && r_cnt == '0) |=> (r_held_valid && r_held_col < CW'(COLS)))
        else $error("column divide ended without a valid held cell");

    a_out_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.key_col < CW'(COLS) && o_out_data.key_row < RW'(ROWS - 1)
                         || o_out_valid && o_out_data.key_row == RW'(ROWS - 1)
                            && o_out_data.key_col < CW'(COLS)))
        else $error("event outside key matrix");

    a_run_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> $stable(r_out_data))
        else $error("stalled event beat changed");

endmodule

`default_nettype wire
